[rtl/ash_pkg.sv]
// Package for the annular sector hit test: widths, register indexes, shared types and the arctangent table.
`timescale 1ns / 1ps

package ash_pkg;

    // Geometry of the data path.
    localparam int COORD_BITS   = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int RING_WIDTH   = 50;
    localparam int EDGE_MARGIN  = 10;

    localparam int RADIUS_W     = 14;
    localparam int ANGLE_REG_W  = 16;
    localparam int CFG_W        = (COORD_BITS > ANGLE_REG_W) ? COORD_BITS : ANGLE_REG_W;
    localparam int CFG_IDX_W    = 3;

    // A coordinate difference needs one bit more than a coordinate.
    localparam int DIFF_W       = COORD_BITS + 1;
    // The sum of two squared differences.
    localparam int D2_W         = 2 * COORD_BITS + 1;
    localparam int OUTER_W      = RADIUS_W + 1;
    localparam int SQ_W         = (D2_W > 2 * OUTER_W) ? D2_W : 2 * OUTER_W;

    // Vectoring CORDIC: the vector is scaled by 2^28 and grows by the CORDIC gain and by root two.
    localparam int CORDIC_SCALE = 28;
    localparam int CORDIC_ITERS = 32;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int CW           = DIFF_W + CORDIC_SCALE + 3;
    localparam int Z_W          = 32;

    // Quadrant codes, the top two bits of a 32-bit binary angle.
    localparam logic [1:0] QUAD_ZERO    = 2'd0;
    localparam logic [1:0] QUAD_QUARTER = 2'd1;
    localparam logic [1:0] QUAD_HALF    = 2'd2;
    localparam logic [1:0] QUAD_THREE   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_ANGLE    = 3'd4;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] center_x;
        logic signed [COORD_BITS-1:0] center_y;
        logic [RADIUS_W-1:0]          outer_radius;
        logic [ANGLE_REG_W-1:0]       start_angle;
        logic [ANGLE_REG_W-1:0]       end_angle;
    } t_cfg;

    // Word carried through the CORDIC pipeline.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [Z_W-1:0]       z;
        logic                 axis;
        logic [1:0]           axis_quad;
        logic                 dist_ok;
    } t_cordic;

    // atan(2^-i) in units of 2^32 per full turn, rounded to nearest.
    function automatic logic [Z_W-1:0] atan_val(input logic [ITER_W-1:0] i);
        logic [Z_W-1:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

[rtl/ash_front.sv]
// Front end: coordinate differences, squared distance test and CORDIC set-up over three stages.
`timescale 1ns / 1ps

module ash_front
    import ash_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  t_cfg                         i_cfg,
    output logic                         o_vld,
    output t_cordic                      o_data
);

    localparam logic [RADIUS_W-1:0] INNER_OFF  = RADIUS_W'(RING_WIDTH + EDGE_MARGIN);
    localparam logic [OUTER_W-1:0]  MARGIN_EXT = OUTER_W'(EDGE_MARGIN);

    // Stage 1: differences and radius bounds.
    logic                     r1_vld;
    logic signed [DIFF_W-1:0] r1_dx, r1_dy;
    logic [OUTER_W-1:0]       r1_outer;
    logic [RADIUS_W-1:0]      r1_inner;
    logic                     r1_inner_pos;

    // Stage 2: squares and the starting CORDIC vector.
    logic                     r2_vld;
    logic [2*COORD_BITS-1:0]  r2_dx2, r2_dy2;
    logic [2*OUTER_W-1:0]     r2_out2;
    logic [2*RADIUS_W-1:0]    r2_in2;
    logic                     r2_inner_pos;
    t_cordic                  r2_cor;

    // Stage 3: distance verdict.
    logic                     r3_vld;
    t_cordic                  r3_cor;

    logic signed [2*DIFF_W-1:0] n_dx2_full, n_dy2_full;
    logic signed [DIFF_W-1:0]   n_xd, n_yd;
    logic                       n_dx_neg;
    t_cordic                    n_cor2;
    logic [D2_W-1:0]            n_d2;
    logic [SQ_W-1:0]            n_d2_ext, n_out2_ext, n_in2_ext;
    t_cordic                    n_cor3;

    always_comb begin
        n_dx2_full = r1_dx * r1_dx;
        n_dy2_full = r1_dy * r1_dy;

        // A vector in the left half-plane is turned by a half turn first.
        n_dx_neg = r1_dx[DIFF_W-1];
        n_xd     = n_dx_neg ? -r1_dx : r1_dx;
        n_yd     = n_dx_neg ? -r1_dy : r1_dy;

        n_cor2.x       = CW'(n_xd) <<< CORDIC_SCALE;
        n_cor2.y       = CW'(n_yd) <<< CORDIC_SCALE;
        n_cor2.z       = n_dx_neg ? {QUAD_HALF, (Z_W-2)'(0)} : '0;
        n_cor2.dist_ok = 1'b0;

        // Points on an axis, the centre included, take an exact angle.
        if (r1_dy == '0) begin
            n_cor2.axis      = 1'b1;
            n_cor2.axis_quad = n_dx_neg ? QUAD_HALF : QUAD_ZERO;
        end else if (r1_dx == '0) begin
            n_cor2.axis      = 1'b1;
            n_cor2.axis_quad = r1_dy[DIFF_W-1] ? QUAD_THREE : QUAD_QUARTER;
        end else begin
            n_cor2.axis      = 1'b0;
            n_cor2.axis_quad = QUAD_ZERO;
        end
    end

    always_comb begin
        n_d2       = D2_W'(r2_dx2) + D2_W'(r2_dy2);
        n_d2_ext   = SQ_W'(n_d2);
        n_out2_ext = SQ_W'(r2_out2);
        n_in2_ext  = SQ_W'(r2_in2);

        n_cor3         = r2_cor;
        n_cor3.dist_ok = (n_d2_ext <= n_out2_ext) &&
                         !(r2_inner_pos && (n_d2_ext < n_in2_ext));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_dx        <= DIFF_W'(i_point_x) - DIFF_W'(i_cfg.center_x);
        r1_dy        <= DIFF_W'(i_point_y) - DIFF_W'(i_cfg.center_y);
        r1_outer     <= OUTER_W'(i_cfg.outer_radius) + MARGIN_EXT;
        r1_inner     <= i_cfg.outer_radius - INNER_OFF;
        r1_inner_pos <= i_cfg.outer_radius > INNER_OFF;

        r2_dx2       <= n_dx2_full[2*COORD_BITS-1:0];
        r2_dy2       <= n_dy2_full[2*COORD_BITS-1:0];
        r2_out2      <= r1_outer * r1_outer;
        r2_in2       <= r1_inner * r1_inner;
        r2_inner_pos <= r1_inner_pos;
        r2_cor       <= n_cor2;

        r3_cor       <= n_cor3;
    end

    assign o_vld  = r3_vld;
    assign o_data = r3_cor;

endmodule

[rtl/ash_cordic.sv]
// Vectoring CORDIC pipeline with one registered stage for each micro-rotation.
`timescale 1ns / 1ps

module ash_cordic
    import ash_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_cordic i_data,
    output logic    o_vld,
    output t_cordic o_data
);

    logic [CORDIC_ITERS-1:0] r_vld;
    t_cordic                 r_dat [CORDIC_ITERS];
    t_cordic                 w_src [CORDIC_ITERS+1];

    assign w_src[0] = i_data;

    for (genvar k = 0; k < CORDIC_ITERS; k++) begin : g_stage
        logic signed [CW-1:0] sx, sy, xs, ys;
        t_cordic              n_dat;

        assign w_src[k+1] = r_dat[k];

        always_comb begin
            sx    = w_src[k].x;
            sy    = w_src[k].y;
            xs    = sx >>> k;
            ys    = sy >>> k;
            n_dat = w_src[k];
            // Rotate towards the x axis and accumulate the angle turned.
            if (sy > 0) begin
                n_dat.x = sx + ys;
                n_dat.y = sy - xs;
                n_dat.z = w_src[k].z + atan_val(ITER_W'(k));
            end else begin
                n_dat.x = sx - ys;
                n_dat.y = sy + xs;
                n_dat.z = w_src[k].z - atan_val(ITER_W'(k));
            end
        end

        always_ff @(posedge i_clk) begin
            r_dat[k] <= n_dat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CORDIC_ITERS-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[CORDIC_ITERS-1];
    assign o_data = w_src[CORDIC_ITERS];

endmodule

[rtl/ash_sector.sv]
// Final stage: angle range check against the arc limits and the registered result.
`timescale 1ns / 1ps

module ash_sector
    import ash_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_vld,
    input  t_cordic i_data,
    input  t_cfg    i_cfg,
    output logic    o_done,
    output logic    o_inside
);

    logic                        r_done;
    logic                        r_inside;
    logic [Z_W-1:0]              n_z;
    logic [ANGLE_BITS-1:0]       n_ang, n_lo, n_hi;
    logic [ANGLE_BITS+ANGLE_REG_W-1:0] n_lo_ext, n_hi_ext;
    logic                        n_in_arc;

    always_comb begin
        n_z      = i_data.axis ? {i_data.axis_quad, (Z_W-2)'(0)} : i_data.z;
        n_ang    = n_z[Z_W-1 -: ANGLE_BITS];
        n_lo_ext = {ANGLE_BITS'(0), i_cfg.start_angle};
        n_hi_ext = {ANGLE_BITS'(0), i_cfg.end_angle};
        n_lo     = n_lo_ext[ANGLE_BITS-1:0];
        n_hi     = n_hi_ext[ANGLE_BITS-1:0];
        // A start beyond the end means the arc wraps through zero.
        if (n_lo <= n_hi) begin
            n_in_arc = (n_ang >= n_lo) && (n_ang <= n_hi);
        end else begin
            n_in_arc = (n_ang >= n_lo) || (n_ang <= n_hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside <= i_data.dist_ok && n_in_arc;
    end

    assign o_done   = r_done;
    assign o_inside = r_inside;

endmodule

[rtl/annular_sector_hit_test.sv]
// Top level of the annular sector hit test: configuration registers and the result pipeline.
`timescale 1ns / 1ps

// Channel        Ports                                  Handshake
// -------------  -------------------------------------  --------------------------------
// point in       i_point_x, i_point_y                   start high while busy is low
// result out     o_inside_res                           o_done high for one cycle
// configuration  i_cfg_we, i_cfg_idx, i_cfg_data        written when i_cfg_we is high
//
// A point word is taken in every cycle in which start is high. Its result strobe comes out of a
// three-stage front end (differences, squares, distance compare), the 32-stage CORDIC and one
// stage for the angle compare, all registered in that order.
// Reset is synchronous and active low; it clears the valid bits and loads the register defaults.
// The receiver cannot stall, so busy stays low and nothing is ever held back.

module annular_sector_hit_test
    import ash_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    output logic                         o_done,
    output logic                         o_inside_res,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    t_cfg    r_cfg;
    t_cfg    n_cfg;
    logic    w_accept;
    logic    w_front_vld, w_cordic_vld;
    t_cordic w_front_dat, w_cordic_dat;

    // Every stage advances in every cycle, so the block is never busy.
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Register writes; an index beyond the list is ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_X:     n_cfg.center_x     = i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_Y:     n_cfg.center_y     = i_cfg_data[COORD_BITS-1:0];
                CFG_OUTER_RADIUS: n_cfg.outer_radius = i_cfg_data[RADIUS_W-1:0];
                CFG_START_ANGLE:  n_cfg.start_angle  = i_cfg_data[ANGLE_REG_W-1:0];
                CFG_END_ANGLE:    n_cfg.end_angle    = i_cfg_data[ANGLE_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x     <= '0;
            r_cfg.center_y     <= '0;
            r_cfg.outer_radius <= '0;
            r_cfg.start_angle  <= '0;
            r_cfg.end_angle    <= '1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Distance test and CORDIC set-up.
    ash_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_vld     (w_accept),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .i_cfg     (r_cfg),
        .o_vld     (w_front_vld),
        .o_data    (w_front_dat)
    );

    // Angle of the offset vector; the distance verdict travels alongside.
    ash_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_data  (w_front_dat),
        .o_vld   (w_cordic_vld),
        .o_data  (w_cordic_dat)
    );

    // Arc limits and the output register.
    ash_sector u_sector (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_cordic_vld),
        .i_data   (w_cordic_dat),
        .i_cfg    (r_cfg),
        .o_done   (o_done),
        .o_inside (o_inside_res)
    );

endmodule
